// ----- src/met_pkg.sv -----
package met_pkg;

   localparam int WORD_W      = 32;
   localparam int WIDE_W      = 64;
   localparam int COORD_W     = 12;
   localparam int STEP_W      = 31;
   localparam int COUNT_W     = 16;
   localparam int PROD_W      = COORD_W + STEP_W;
   localparam int ADDR_W      = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [WORD_W-1:0]  RESET_REAL_MIN  = 32'hE000_0000;
   localparam logic [WORD_W-1:0]  RESET_IMAG_MAX  = 32'h1800_0000;
   localparam logic [STEP_W-1:0]  RESET_REAL_STEP = 31'd1048576;
   localparam logic [STEP_W-1:0]  RESET_IMAG_STEP = 31'd1048576;
   localparam logic [COUNT_W-1:0] RESET_MAX_ITER  = 16'd64;
   localparam logic [COUNT_W-1:0] RESET_LIGHT_THR = 16'd63;

   typedef enum logic [2:0] {
      REG_REAL_MIN        = 3'd0,
      REG_IMAG_MAX        = 3'd1,
      REG_REAL_STEP       = 3'd2,
      REG_IMAG_STEP       = 3'd3,
      REG_MAX_ITERATIONS  = 3'd4,
      REG_LIGHT_THRESHOLD = 3'd5
   } met_reg_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_RUN,
      BACK_HOLD
   } met_back_state_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] real_min;
      logic signed [WORD_W-1:0] imag_max;
      logic [STEP_W-1:0]        real_step;
      logic [STEP_W-1:0]        imag_step;
      logic [COUNT_W-1:0]       max_iterations;
      logic [COUNT_W-1:0]       light_threshold;
   } met_cfg_type;

   typedef struct packed {
      logic [COORD_W-1:0]       x;
      logic [COORD_W-1:0]       y;
      logic signed [WORD_W-1:0] c_re;
      logic signed [WORD_W-1:0] c_im;
   } met_job_type;

   // clamp a wide two's complement value to the 32-bit word
   function automatic logic [WORD_W-1:0] sat_word(input logic [WIDE_W-1:0] v);
      logic [WORD_W-1:0] r;
      if ((&v[WIDE_W-1:WORD_W-1]) || !(|v[WIDE_W-1:WORD_W-1])) begin
         r = v[WORD_W-1:0];
      end else if (v[WIDE_W-1]) begin
         r = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(WORD_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// ----- src/met_channels.sv -----
interface met_req_if import met_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pixel_x;
   logic [COORD_W-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface met_rsp_if import met_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] out_x;
   logic [COORD_W-1:0] out_y;
   logic [COUNT_W-1:0] iteration_count;
   logic               is_light;

   modport source (output valid, output out_x, output out_y, output iteration_count,
                   output is_light, input ready);
   modport sink (input valid, input out_x, input out_y, input iteration_count,
                 input is_light, output ready);
endinterface

// ----- src/met_front.sv -----
module met_front import met_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   met_req_if.sink     req,
   input  met_cfg_type cfg,
   output logic        push_valid,
   output met_job_type push_job,
   input  logic        push_ready
);

   logic               s1_valid_ff, s1_valid_in;
   logic [COORD_W-1:0] s1_x_ff, s1_x_in;
   logic [COORD_W-1:0] s1_y_ff, s1_y_in;
   logic [PROD_W-1:0]  s1_re_prod_ff, s1_re_prod_in;
   logic [PROD_W-1:0]  s1_im_prod_ff, s1_im_prod_in;
   logic               accept;
   logic [WIDE_W-1:0]  re_sum;
   logic [WIDE_W-1:0]  im_sum;

   assign req.ready = !s1_valid_ff || push_ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      s1_x_in       = req.pixel_x;
      s1_y_in       = req.pixel_y;
      s1_re_prod_in = PROD_W'(req.pixel_x) * PROD_W'(cfg.real_step);
      s1_im_prod_in = PROD_W'(req.pixel_y) * PROD_W'(cfg.imag_step);
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (push_ready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_x_ff       <= s1_x_in;
         s1_y_ff       <= s1_y_in;
         s1_re_prod_ff <= s1_re_prod_in;
         s1_im_prod_ff <= s1_im_prod_in;
      end
   end

   // c = origin +/- pixel * step, clamped to the word
   assign re_sum = {{WORD_W{cfg.real_min[WORD_W-1]}}, cfg.real_min} + WIDE_W'(s1_re_prod_ff);
   assign im_sum = {{WORD_W{cfg.imag_max[WORD_W-1]}}, cfg.imag_max} - WIDE_W'(s1_im_prod_ff);

   assign push_valid    = s1_valid_ff;
   assign push_job.x    = s1_x_ff;
   assign push_job.y    = s1_y_ff;
   assign push_job.c_re = sat_word(re_sum);
   assign push_job.c_im = sat_word(im_sum);

endmodule

// ----- src/met_queue.sv -----
module met_queue import met_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   input  met_job_type push_job,
   output logic        push_ready,
   output logic        pop_valid,
   output met_job_type pop_job,
   input  logic        pop_ready
);

   met_job_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign push_ready = (fill_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_job    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- src/met_back.sv -----
module met_back import met_pkg::*; #(
   parameter int FRAC_BITS = 28
) (
   input  logic        clock,
   input  logic        reset,
   input  met_cfg_type cfg,
   input  logic        pop_valid,
   input  met_job_type pop_job,
   output logic        pop_ready,
   met_rsp_if.source   rsp
);

   // |z|^2 >= 4 at 2*FRAC_BITS fraction bits
   localparam logic [WIDE_W-1:0] ESCAPE_LIMIT = WIDE_W'(1) << (2 * FRAC_BITS + 2);

   met_back_state_type       state_ff, state_in;
   logic signed [WORD_W-1:0] re_ff, re_in;
   logic signed [WORD_W-1:0] im_ff, im_in;
   logic signed [WORD_W-1:0] c_re_ff, c_im_ff;
   logic [COORD_W-1:0]       x_ff, y_ff;
   logic [COUNT_W-1:0]       count_ff, count_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]       out_x_ff, out_y_ff;
   logic [COUNT_W-1:0]       out_count_ff;
   logic                     out_light_ff;

   logic signed [WIDE_W-1:0] rr, ii, ri;
   logic signed [WIDE_W-1:0] diff, re_shift, im_shift;
   logic signed [WIDE_W-1:0] c_re_ext, c_im_ext;
   logic signed [WIDE_W-1:0] re_sum, im_sum;
   logic [WIDE_W-1:0]        mag;
   logic                     escape, done, out_free;
   logic                     load_job, step, load_out;

   assign rr       = re_ff * re_ff;
   assign ii       = im_ff * im_ff;
   assign ri       = re_ff * im_ff;
   assign mag      = WIDE_W'(rr) + WIDE_W'(ii);
   assign escape   = (mag >= ESCAPE_LIMIT);
   assign done     = (count_ff >= cfg.max_iterations) || escape;

   assign c_re_ext = {{WORD_W{c_re_ff[WORD_W-1]}}, c_re_ff};
   assign c_im_ext = {{WORD_W{c_im_ff[WORD_W-1]}}, c_im_ff};
   assign diff     = rr - ii;
   assign re_shift = diff >>> FRAC_BITS;
   assign im_shift = ri >>> (FRAC_BITS - 1);   // doubles re*im
   assign re_sum   = re_shift + c_re_ext;
   assign im_sum   = im_shift + c_im_ext;

   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (pop_valid) begin
               state_in = BACK_RUN;
            end
         end
         BACK_RUN: begin
            if (done) begin
               state_in = out_free ? BACK_IDLE : BACK_HOLD;
            end
         end
         BACK_HOLD: begin
            if (out_free) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      pop_ready = 1'b0;
      load_job  = 1'b0;
      step      = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            pop_ready = 1'b1;
            load_job  = pop_valid;
         end
         BACK_RUN: begin
            step     = !done;
            load_out = done && out_free;
         end
         BACK_HOLD: begin
            load_out = out_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      re_in    = re_ff;
      im_in    = im_ff;
      count_in = count_ff;
      if (load_job) begin
         re_in    = '0;
         im_in    = '0;
         count_in = '0;
      end else if (step) begin
         re_in    = sat_word(re_sum);
         im_in    = sat_word(im_sum);
         count_in = count_ff + 1'b1;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      re_ff    <= re_in;
      im_ff    <= im_in;
      count_ff <= count_in;
      if (load_job) begin
         c_re_ff <= pop_job.c_re;
         c_im_ff <= pop_job.c_im;
         x_ff    <= pop_job.x;
         y_ff    <= pop_job.y;
      end
      if (load_out) begin
         out_x_ff     <= x_ff;
         out_y_ff     <= y_ff;
         out_count_ff <= count_ff;
         out_light_ff <= (count_ff < cfg.light_threshold);
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.out_x           = out_x_ff;
   assign rsp.out_y           = out_y_ff;
   assign rsp.iteration_count = out_count_ff;
   assign rsp.is_light        = out_light_ff;

endmodule

// ----- src/mandelbrot_escape_time_pixel.sv -----
// Mandelbrot escape-time evaluator, one pixel per item.
// req_chan (sink): pixel_x, pixel_y. rsp_chan (source): out_x, out_y,
// iteration_count and is_light (count below light_threshold). Both channels
// move an item on a clock edge with valid and ready high.
// csr_*: APB-style register port, registers at byte address 4*i:
// real_min, imag_max, real_step, imag_step, max_iterations, light_threshold.
// Write registers only while no item is in flight.
// Front end: pixel*step is registered, then the origin is added, c is
// clamped and pushed into a 2-entry queue. Back end: takes a job in
// BACK_IDLE, runs one iteration per cycle in BACK_RUN (three 32x32
// multiplies feed the update and the escape test), then loads the result
// register. The back end takes a new job only once the last one is
// posted, so throughput is set by the iteration loop.
// While a result waits on rsp_chan the back end takes and runs the next job
// and stalls only when that one finishes; the front end keeps filling the
// queue. Reset (synchronous) empties the pipe and loads default registers.
module mandelbrot_escape_time_pixel import met_pkg::*; #(
   parameter int FRAC_BITS = 28
) (
   input  logic              clock,
   input  logic              reset,
   met_req_if.sink           req_chan,
   met_rsp_if.source         rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [WORD_W-1:0] csr_pwdata,
   output logic [WORD_W-1:0] csr_prdata,
   output logic              csr_pready
);

   met_cfg_type cfg_ff, cfg_in;
   met_reg_type reg_sel;
   logic        csr_write;

   logic        push_valid, push_ready;
   met_job_type push_job;
   logic        pop_valid, pop_ready;
   met_job_type pop_job;

   // ---- register port ----
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = met_reg_type'(csr_paddr[ADDR_W-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_sel)
            REG_REAL_MIN:        cfg_in.real_min        = csr_pwdata;
            REG_IMAG_MAX:        cfg_in.imag_max        = csr_pwdata;
            REG_REAL_STEP:       cfg_in.real_step       = csr_pwdata[STEP_W-1:0];
            REG_IMAG_STEP:       cfg_in.imag_step       = csr_pwdata[STEP_W-1:0];
            REG_MAX_ITERATIONS:  cfg_in.max_iterations  = csr_pwdata[COUNT_W-1:0];
            REG_LIGHT_THRESHOLD: cfg_in.light_threshold = csr_pwdata[COUNT_W-1:0];
            default: ;   // unmapped address, write dropped
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_REAL_MIN:        csr_prdata = cfg_ff.real_min;
         REG_IMAG_MAX:        csr_prdata = cfg_ff.imag_max;
         REG_REAL_STEP:       csr_prdata = WORD_W'(cfg_ff.real_step);
         REG_IMAG_STEP:       csr_prdata = WORD_W'(cfg_ff.imag_step);
         REG_MAX_ITERATIONS:  csr_prdata = WORD_W'(cfg_ff.max_iterations);
         REG_LIGHT_THRESHOLD: csr_prdata = WORD_W'(cfg_ff.light_threshold);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.real_min        <= RESET_REAL_MIN;
         cfg_ff.imag_max        <= RESET_IMAG_MAX;
         cfg_ff.real_step       <= RESET_REAL_STEP;
         cfg_ff.imag_step       <= RESET_IMAG_STEP;
         cfg_ff.max_iterations  <= RESET_MAX_ITER;
         cfg_ff.light_threshold <= RESET_LIGHT_THR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- front end: pixel to c ----
   met_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   // ---- job queue between the two halves ----
   met_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready)
   );

   // ---- back end: z = z*z + c iteration and result register ----
   met_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_job   (pop_job),
      .pop_ready (pop_ready),
      .rsp       (rsp_chan)
   );

endmodule

// ----- src/met_checker.sv -----
module met_checker import met_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [COORD_W-1:0] rsp_out_x,
   input logic [COORD_W-1:0] rsp_out_y,
   input logic [COUNT_W-1:0] rsp_iteration_count,
   input logic               rsp_is_light,
   input logic               csr_psel,
   input logic               csr_penable,
   input logic               csr_pwrite,
   input logic [ADDR_W-1:0]  csr_paddr,
   input logic [WORD_W-1:0]  csr_pwdata,
   input logic [WORD_W-1:0]  csr_prdata
);

   logic csr_wr_limit;

   assign csr_wr_limit = csr_psel && csr_penable && csr_pwrite
                         && (csr_paddr[ADDR_W-1:2] == REG_MAX_ITERATIONS);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_x) && $stable(rsp_out_y)
                                  && $stable(rsp_iteration_count) && $stable(rsp_is_light))
      else $error("result changed while stalled");

   a_limit_readback: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(csr_wr_limit)
      && (csr_paddr[ADDR_W-1:2] == REG_MAX_ITERATIONS)
      |-> (csr_prdata == WORD_W'($past(csr_pwdata[COUNT_W-1:0]))))
      else $error("iteration limit readback mismatch");

endmodule

bind mandelbrot_escape_time_pixel met_checker u_met_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_out_x           (rsp_chan.out_x),
   .rsp_out_y           (rsp_chan.out_y),
   .rsp_iteration_count (rsp_chan.iteration_count),
   .rsp_is_light        (rsp_chan.is_light),
   .csr_psel            (csr_psel),
   .csr_penable         (csr_penable),
   .csr_pwrite          (csr_pwrite),
   .csr_paddr           (csr_paddr),
   .csr_pwdata          (csr_pwdata),
   .csr_prdata          (csr_prdata)
);
